@@ src/lsact_pkg.sv @@
// Shared types and constants of the LRU set-associative cache tracker.
// Holds the request codes, register indexes, controller states and the
// command and status groups between controller and datapath. No dependencies.
package lsact_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int TOTAL_W    = 32;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Request kinds; the unused code behaves as a load
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

    // Configuration reset values
    localparam logic [2:0] SET_INDEX_BITS_RST    = 3'd0;
    localparam logic [5:0] BLOCK_OFFSET_BITS_RST = 6'd0;
    localparam logic [3:0] WAYS_IN_USE_RST       = 4'd1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_en;
        logic req_ready;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic req_valid;
        logic clear_last;
        logic rsp_stall;
    } t_ctrl_status;

endpackage

@@ src/lsact_if.sv @@
// Handshake channel interfaces of the cache tracker: request, response and
// configuration write. Each carries valid, ready and its payload.
// Depends on lsact_pkg.
interface lsact_req_if import lsact_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface lsact_rsp_if import lsact_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit_flag;
    logic               miss_flag;
    logic               eviction_flag;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;

    modport source (output valid, output hit_flag, output miss_flag, output eviction_flag,
                    output total_hits, output total_misses, output total_evictions,
                    input ready);
    modport sink   (input valid, input hit_flag, input miss_flag, input eviction_flag,
                    input total_hits, input total_misses, input total_evictions,
                    output ready);
endinterface

interface lsact_cfg_if import lsact_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ src/lru_set_assoc_cache_tracker.sv @@
// LRU set-associative cache tracker. Each request item carries an access kind and
// a 64-bit byte address; the block splits it into set index and tag with the
// configured bit counts, looks the tag up among the set's lines, updates the LRU
// ranks, fills or evicts on a miss, and returns one response item with hit, miss
// and eviction flags and the saturating running totals. An item is accepted in the
// idle state, which reads the set's tag and metadata rows from memory; the update
// state then compares, updates and writes them back. No new item is accepted until
// the update completes, and the update waits while a response is still unread.
// After reset the block clears the valid marks of all 2^SET_BITS_MAX sets in a pass
// and takes no request items meanwhile; configuration writes are taken at any time.
module lru_set_assoc_cache_tracker import lsact_pkg::*; #(
    parameter int SET_BITS_MAX = 6,
    parameter int WAYS_MAX     = 8,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsact_cfg_if.sink   i_cfg,
    lsact_req_if.sink   i_req,
    lsact_rsp_if.source o_rsp
);

    t_ctrl_cmd    ctrl_cmd;
    t_ctrl_status ctrl_status;

    // Sequencing
    lsact_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (ctrl_status),
        .o_cmd    (ctrl_cmd)
    );

    // Lookup, storage and counters
    lsact_dpath #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS_MAX     (WAYS_MAX),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctrl_cmd),
        .o_status (ctrl_status),
        .i_cfg    (i_cfg),
        .i_req    (i_req),
        .o_rsp    (o_rsp)
    );

endmodule

@@ src/lsact_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds while no read is issued. No dependencies.
module lsact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lsact_ctrl.sv @@
// Controller of the cache tracker: clearing pass after reset, accepting an
// item, and the update step that waits for the response register to free.
// Depends on lsact_pkg.
module lsact_ctrl import lsact_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_status.req_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!i_status.rsp_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.req_ready = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.commit = !i_status.rsp_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ src/lsact_dpath.sv @@
// Datapath of the cache tracker: configuration registers, address split,
// tag and metadata memories, lookup with LRU update, counters and response.
// Depends on lsact_pkg, lsact_if and lsact_ram.
module lsact_dpath import lsact_pkg::*; #(
    parameter int SET_BITS_MAX = 6,
    parameter int WAYS_MAX     = 8,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl_cmd    i_cmd,
    output t_ctrl_status o_status,
    lsact_cfg_if.sink    i_cfg,
    lsact_req_if.sink    i_req,
    lsact_rsp_if.source  o_rsp
);

    localparam int NUM_SETS = 1 << SET_BITS_MAX;
    localparam int SW       = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int RW       = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
    localparam int CNTW     = $clog2(WAYS_MAX + 1);
    localparam int MW       = RW + 1;

    // Configuration registers
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;

    // Accepted item
    logic [SW-1:0]    r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_modify;

    // Clearing pass
    logic [SW-1:0] r_clr_addr;

    // Counters and response
    logic [COUNT_WIDTH-1:0] r_hits;
    logic [COUNT_WIDTH-1:0] r_misses;
    logic [COUNT_WIDTH-1:0] r_evicts;
    logic                   r_rsp_valid;
    logic                   r_hit_flag;
    logic                   r_miss_flag;
    logic                   r_evict_flag;

    // Address split
    logic [3:0]        sbits_eff;
    logic [ADDR_W-1:0] addr_shr;
    logic [SW-1:0]     set_mask;
    logic [SW-1:0]     acc_set;
    logic [6:0]        tag_shift;
    logic [TAG_W-1:0]  acc_tag;
    logic              accept;

    // Lookup
    logic [WAYS_MAX*TAG_W-1:0]            tag_rdata;
    logic [WAYS_MAX*MW-1:0]               meta_rdata;
    logic [WAYS_MAX-1:0][TAG_W-1:0]       tag_row;
    logic [WAYS_MAX-1:0][MW-1:0]          meta_row;
    logic [WAYS_MAX-1:0][TAG_W-1:0]       n_tag_row;
    logic [WAYS_MAX-1:0][MW-1:0]          n_meta_row;
    logic [WAYS_MAX-1:0]                  way_valid;
    logic [WAYS_MAX-1:0][RW-1:0]          way_rank;
    logic [WAYS_MAX-1:0]                  way_match;
    logic [WAYS_MAX-1:0]                  match_1h;
    logic [WAYS_MAX-1:0]                  free_1h;
    logic [WAYS_MAX-1:0]                  lru_1h;
    logic [WAYS_MAX-1:0]                  fill_1h;
    logic [CNTW-1:0]                      valid_count;
    logic [CNTW-1:0]                      ways_eff;
    logic [RW-1:0]                        lru_rank;
    logic [RW-1:0]                        hit_rank;
    logic                                 hit;
    logic                                 evict;
    logic [1:0]                           hits_inc;

    // Memory ports
    logic          meta_we;
    logic [SW-1:0] meta_waddr;
    logic [WAYS_MAX*MW-1:0] meta_wdata;

    // Saturating add of a small increment
    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] value,
                                                       input logic [1:0] inc);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, value} + (COUNT_WIDTH + 1)'(inc);
        return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    endfunction

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SET_INDEX_BITS_RST;
            r_block_bits <= BLOCK_OFFSET_BITS_RST;
            r_ways       <= WAYS_IN_USE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_SET_INDEX_BITS:    r_set_bits   <= i_cfg.wr_data[2:0];
                CFG_BLOCK_OFFSET_BITS: r_block_bits <= i_cfg.wr_data[5:0];
                CFG_WAYS_IN_USE:       r_ways       <= i_cfg.wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Split the incoming address into set index and tag
    always_comb begin
        sbits_eff = ({1'b0, r_set_bits} > 4'(SET_BITS_MAX)) ? 4'(SET_BITS_MAX)
                                                             : {1'b0, r_set_bits};
        addr_shr  = i_req.address >> r_block_bits;
        for (int i = 0; i < SW; i++) begin
            set_mask[i] = (4'(i) < sbits_eff);
        end
        acc_set   = addr_shr[SW-1:0] & set_mask;
        tag_shift = 7'(r_block_bits) + 7'(sbits_eff);
        acc_tag   = tag_shift[6] ? '0 : (i_req.address >> tag_shift[5:0]);
    end

    assign accept      = i_req.valid && i_cmd.req_ready;
    assign i_req.ready = i_cmd.req_ready;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set    <= acc_set;
            r_tag    <= acc_tag;
            r_modify <= (i_req.req_type == REQ_MODIFY);
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Tags of one set in one row
    lsact_ram #(
        .WIDTH (WAYS_MAX * TAG_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && !hit),
        .i_waddr (r_set),
        .i_wdata (n_tag_row),
        .i_re    (accept),
        .i_raddr (acc_set),
        .o_rdata (tag_rdata)
    );

    // Valid marks and recency ranks of one set in one row
    assign meta_we    = i_cmd.clear_en || i_cmd.commit;
    assign meta_waddr = i_cmd.clear_en ? r_clr_addr : r_set;
    assign meta_wdata = i_cmd.clear_en ? '0 : n_meta_row;

    lsact_ram #(
        .WIDTH (WAYS_MAX * MW),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (accept),
        .i_raddr (acc_set),
        .o_rdata (meta_rdata)
    );

    // Associativity clamped to 1 .. WAYS_MAX
    always_comb begin
        if (r_ways == 4'd0) begin
            ways_eff = CNTW'(1);
        end else if ({2'b0, r_ways} > 6'(WAYS_MAX)) begin
            ways_eff = CNTW'(WAYS_MAX);
        end else begin
            ways_eff = CNTW'(r_ways);
        end
    end

    // Lookup and LRU update. Valid lines of a set hold distinct ranks
    // 0 .. count-1, so the least recent line is the one ranked count-1.
    always_comb begin
        tag_row  = tag_rdata;
        meta_row = meta_rdata;
        for (int w = 0; w < WAYS_MAX; w++) begin
            way_valid[w] = meta_row[w][RW];
            way_rank[w]  = meta_row[w][RW-1:0];
            way_match[w] = way_valid[w] && (tag_row[w] == r_tag);
        end
        valid_count = CNTW'($countones(way_valid));
        lru_rank    = RW'(valid_count - CNTW'(1));
        match_1h    = way_match & (~way_match + WAYS_MAX'(1));
        free_1h     = ~way_valid & (way_valid + WAYS_MAX'(1));
        hit         = |way_match;
        evict       = !hit && (valid_count >= ways_eff);
        hit_rank    = '0;
        for (int w = 0; w < WAYS_MAX; w++) begin
            lru_1h[w] = way_valid[w] && (way_rank[w] == lru_rank);
            if (match_1h[w]) begin
                hit_rank = hit_rank | way_rank[w];
            end
        end
        fill_1h = evict ? lru_1h : free_1h;

        for (int w = 0; w < WAYS_MAX; w++) begin
            n_meta_row[w] = meta_row[w];
            n_tag_row[w]  = tag_row[w];
            if (hit) begin
                if (match_1h[w]) begin
                    n_meta_row[w][RW-1:0] = '0;
                end else if (way_valid[w] && (way_rank[w] < hit_rank)) begin
                    n_meta_row[w][RW-1:0] = way_rank[w] + 1'b1;
                end
            end else if (fill_1h[w]) begin
                n_meta_row[w] = {1'b1, {RW{1'b0}}};
                n_tag_row[w]  = r_tag;
            end else if (way_valid[w]) begin
                n_meta_row[w][RW-1:0] = way_rank[w] + 1'b1;
            end
        end
        hits_inc = {1'b0, hit} + {1'b0, r_modify};
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (i_cmd.commit) begin
            r_hits   <= sat_add(r_hits, hits_inc);
            r_misses <= sat_add(r_misses, {1'b0, !hit});
            r_evicts <= sat_add(r_evicts, {1'b0, evict});
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit_flag   <= hit || r_modify;
            r_miss_flag  <= !hit;
            r_evict_flag <= evict;
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.hit_flag        = r_hit_flag;
    assign o_rsp.miss_flag       = r_miss_flag;
    assign o_rsp.eviction_flag   = r_evict_flag;
    assign o_rsp.total_hits      = TOTAL_W'(r_hits);
    assign o_rsp.total_misses    = TOTAL_W'(r_misses);
    assign o_rsp.total_evictions = TOTAL_W'(r_evicts);

    // Status for the controller
    assign o_status.req_valid  = i_req.valid;
    assign o_status.clear_last = (r_clr_addr == SW'(NUM_SETS - 1));
    assign o_status.rsp_stall  = r_rsp_valid && !o_rsp.ready;

endmodule

@@ dv/cache_tracker_checker.sv @@
// Checker of the LRU set-associative cache tracker: watches the configuration, request
// and response channels, predicts each response item and compares it field by field.
// Depends on lsact_pkg and the channel interfaces in lsact_if.sv.
module cache_tracker_checker import lsact_pkg::*; #(
    parameter int SET_BITS_MAX = 6,
    parameter int WAYS_MAX     = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lsact_cfg_if  cfg_mon,
    lsact_req_if  req_mon,
    lsact_rsp_if  rsp_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_compared
);

    localparam int NUM_LINES = (1 << SET_BITS_MAX) * WAYS_MAX;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic               hit;
        logic               miss;
        logic               evict;
        logic [TOTAL_W-1:0] hits;
        logic [TOTAL_W-1:0] misses;
        logic [TOTAL_W-1:0] evictions;
    } t_access_outcome;

    // Shadow copy of the cache contents and the running totals
    logic [TAG_W-1:0]   line_tag  [NUM_LINES];
    logic               line_live [NUM_LINES];
    int unsigned        line_age  [NUM_LINES];
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] evict_total;

    // Shadow copy of the configuration registers
    logic [2:0] cfg_set_bits;
    logic [5:0] cfg_block_bits;
    logic [3:0] cfg_ways;

    t_access_outcome outcome_q [$];
    t_access_outcome seen_want;

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic compare_field(input string field, input logic [TOTAL_W-1:0] want,
                                 input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("response %0d %s expected %0h got %0h",
                                      o_compared, field, want, got));
        end
    endtask

    function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Looks one access up in the shadow cache, updates it and returns the outcome.
    task automatic predict_access(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                                  output t_access_outcome res);
        int unsigned sbits, bbits, nways, shift, set_idx, base, cnt, w, age, worst;
        int found, slot;
        logic [TAG_W-1:0] tag;
        logic [ADDR_W-1:0] set_word;

        sbits = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
        bbits = cfg_block_bits;
        nways = (cfg_ways < 1) ? 1 : ((cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways);
        set_word = (addr >> bbits) & ((64'd1 << sbits) - 64'd1);
        set_idx  = set_word[SET_BITS_MAX:0];
        shift    = bbits + sbits;
        tag      = (shift >= 64) ? '0 : (addr >> shift);
        base     = set_idx * WAYS_MAX;
        cnt      = 0;
        found    = -1;
        slot     = -1;
        worst    = 0;
        res      = '0;

        for (w = 0; w < WAYS_MAX; w++) begin
            if (line_live[base + w]) begin
                cnt++;
                if (found < 0 && line_tag[base + w] == tag) found = w;
            end
        end

        if (found >= 0) begin
            // Hit: lines more recent than this one age by one step.
            age = line_age[base + found];
            res.hit = 1'b1;
            hit_total = bump_total(hit_total);
            for (w = 0; w < WAYS_MAX; w++) begin
                if (line_live[base + w] && line_age[base + w] < age) line_age[base + w]++;
            end
            line_age[base + found] = 0;
        end else begin
            res.miss = 1'b1;
            miss_total = bump_total(miss_total);
            if (cnt >= nways) begin
                // Set full for this associativity: drop the least recent line.
                for (w = 0; w < WAYS_MAX; w++) begin
                    if (line_live[base + w] && (slot < 0 || line_age[base + w] > worst)) begin
                        slot  = w;
                        worst = line_age[base + w];
                    end
                end
                res.evict = 1'b1;
                evict_total = bump_total(evict_total);
                line_live[base + slot] = 1'b0;
            end else begin
                for (w = 0; w < WAYS_MAX; w++) begin
                    if (slot < 0 && !line_live[base + w]) slot = w;
                end
            end
            for (w = 0; w < WAYS_MAX; w++) begin
                if (line_live[base + w]) line_age[base + w]++;
            end
            if (slot >= 0) begin
                line_tag[base + slot]  = tag;
                line_live[base + slot] = 1'b1;
                line_age[base + slot]  = 0;
            end
        end

        // A modify stores after its load, which always hits.
        if (kind == REQ_MODIFY) begin
            res.hit = 1'b1;
            hit_total = bump_total(hit_total);
        end

        res.hits      = hit_total;
        res.misses    = miss_total;
        res.evictions = evict_total;
    endtask

    // Monitor: configuration writes, then responses, then new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                line_live[i] = 1'b0;
                line_age[i]  = 0;
            end
            hit_total      = '0;
            miss_total     = '0;
            evict_total    = '0;
            cfg_set_bits   = SET_INDEX_BITS_RST;
            cfg_block_bits = BLOCK_OFFSET_BITS_RST;
            cfg_ways       = WAYS_IN_USE_RST;
            outcome_q.delete();
            o_pending    = 0;
            o_fail_count = 0;
            o_compared   = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.reg_index)
                    CFG_SET_INDEX_BITS:    cfg_set_bits   = cfg_mon.wr_data[2:0];
                    CFG_BLOCK_OFFSET_BITS: cfg_block_bits = cfg_mon.wr_data[5:0];
                    CFG_WAYS_IN_USE:       cfg_ways       = cfg_mon.wr_data[3:0];
                    default: ;
                endcase
            end

            if (rsp_mon.valid && rsp_mon.ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("response item with no access outstanding");
                end else begin
                    seen_want = outcome_q.pop_front();
                    compare_field("hit_flag", seen_want.hit, rsp_mon.hit_flag);
                    compare_field("miss_flag", seen_want.miss, rsp_mon.miss_flag);
                    compare_field("eviction_flag", seen_want.evict, rsp_mon.eviction_flag);
                    compare_field("total_hits", seen_want.hits, rsp_mon.total_hits);
                    compare_field("total_misses", seen_want.misses, rsp_mon.total_misses);
                    compare_field("total_evictions", seen_want.evictions,
                                  rsp_mon.total_evictions);
                    o_compared++;
                end
            end

            if (req_mon.valid && req_mon.ready) begin
                predict_access(req_mon.req_type, req_mon.address, seen_want);
                outcome_q.push_back(seen_want);
            end

            o_pending = outcome_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the cache tracker testbench: clock, reset, request and configuration
// stimulus, response backpressure and the verdict.
// Depends on lsact_pkg, lsact_if.sv, the tracker RTL and cache_tracker_checker.
module tb_top;
    import lsact_pkg::*;

    localparam int SET_BITS_MAX     = 6;
    localparam int WAYS_MAX         = 8;
    localparam int NUM_PHASES       = 8;
    localparam int ACCESSES_PER_PHASE = 160;
    localparam int POOL_SIZE        = 12;
    localparam int CYCLE_LIMIT      = 300000;

    // Codes that the block does not define
    localparam logic [REQ_W-1:0]     REQ_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    int   accesses_sent;
    int   fail_count;
    int   pending_count;
    int   compared_count;

    // Geometry of each random phase; phases 2 and 6 shift the tag out, phase 3 asks for more ways than WAYS_MAX
    int phase_set_bits  [NUM_PHASES] = '{3, 6, 7, 2, 1, 4, 6, 5};
    int phase_block_bits[NUM_PHASES] = '{4, 6, 63, 5, 0, 58, 60, 3};
    int phase_ways      [NUM_PHASES] = '{4, 8, 0, 15, 2, 3, 8, 1};

    lsact_cfg_if cfg_ch ();
    lsact_req_if req_ch ();
    lsact_rsp_if rsp_ch ();

    lru_set_assoc_cache_tracker #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS_MAX     (WAYS_MAX),
        .COUNT_WIDTH  (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    cache_tracker_checker #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS_MAX     (WAYS_MAX)
    ) tracker_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_mon      (cfg_ch),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_compared   (compared_count)
    );

    // Clock with a period of 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding",
                     cycle_count, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response backpressure, redrawn every cycle
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one access item, with random idle cycles ahead of it.
    task automatic send_access(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = kind;
        req_ch.address  = addr;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        accesses_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Waits until every response has come back and the pipeline has gone quiet.
    task automatic drain_block();
        req_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Rewrites the geometry; unused upper data bits are random.
    task automatic set_geometry(input int sbits, input int bbits, input int nways);
        drain_block();
        write_reg(CFG_SET_INDEX_BITS, (8'($urandom) & 8'hF8) | 8'(sbits));
        write_reg(CFG_BLOCK_OFFSET_BITS, (8'($urandom) & 8'hC0) | 8'(bbits));
        write_reg(CFG_WAYS_IN_USE, (8'($urandom) & 8'hF0) | 8'(nways));
    endtask

    // Address of a line with a small tag (sometimes a wide one) in one of the low sets.
    function automatic logic [ADDR_W-1:0] line_address(input int bbits, input int sbits);
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] set_no;
        tag    = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(5));
        set_no = 64'($urandom_range(3));
        return (tag << (bbits + sbits)) | (set_no << bbits);
    endfunction

    initial begin
        logic [ADDR_W-1:0] hot_lines [POOL_SIZE];
        logic [ADDR_W-1:0] offset_mask;
        logic [ADDR_W-1:0] addr;
        int eff_sbits;
        int pick;

        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wr_data   = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_LOAD;
        req_ch.address   = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        accesses_sent    = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry: one set, one way, byte-sized blocks
        send_access(REQ_LOAD, 64'h0);
        send_access(REQ_LOAD, 64'h0);
        send_access(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(REQ_MODIFY, 64'h0000_0000_0000_005A);
        send_access(REQ_SPARE, 64'h0000_0000_0000_005A);

        // Write to the unused register index, then too many set bits, the widest
        // block offset (tag shifted out) and zero ways
        drain_block();
        write_reg(CFG_SPARE, 8'hFF);
        set_geometry(7, 63, 0);
        send_access(REQ_LOAD, 64'h8000_0000_0000_0000);
        send_access(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(REQ_STORE, 64'h0);
        send_access(REQ_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);

        // Two ways, four sets of 16-byte blocks: LRU order within set 1
        set_geometry(2, 4, 2);
        send_access(REQ_LOAD, 64'h50);
        send_access(REQ_STORE, 64'h90);
        send_access(REQ_LOAD, 64'h50);
        send_access(REQ_LOAD, 64'hD0);
        send_access(REQ_MODIFY, 64'h90);
        send_access(REQ_LOAD, 64'hD0);

        // Associativity lowered while two lines of the set are valid
        set_geometry(2, 4, 1);
        send_access(REQ_LOAD, 64'h110);
        send_access(REQ_STORE, 64'h90);
        send_access(REQ_LOAD, 64'hD0);

        // Random phases, each with its own geometry and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_geometry(phase_set_bits[p], phase_block_bits[p], phase_ways[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            eff_sbits   = (phase_set_bits[p] > SET_BITS_MAX) ? SET_BITS_MAX : phase_set_bits[p];
            offset_mask = (64'd1 << phase_block_bits[p]) - 64'd1;
            for (int i = 0; i < POOL_SIZE; i++) begin
                hot_lines[i] = line_address(phase_block_bits[p], eff_sbits);
            end

            // Mostly reuse of a small working set, some new lines, some noise
            for (int i = 0; i < ACCESSES_PER_PHASE; i++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    addr = hot_lines[$urandom_range(POOL_SIZE - 1)]
                           ^ ({$urandom, $urandom} & offset_mask);
                end else if (pick < 85) begin
                    addr = line_address(phase_block_bits[p], eff_sbits);
                    hot_lines[$urandom_range(POOL_SIZE - 1)] = addr;
                end else begin
                    addr = {$urandom, $urandom};
                end
                send_access(REQ_W'($urandom_range(3)), addr);
            end
        end

        // Let every outstanding response arrive
        req_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Sent %0d accesses under %0d cache geometries; %0d responses checked.",
                 accesses_sent, NUM_PHASES + 4, compared_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
